/* rtl/core/ofrb_pkg.sv */
// Shared types, codes and constants of the overwriting frame ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package ofrb_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W    = 3;
    localparam int CNT_W    = 9;
    localparam int EW_W     = 7;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    // Parameter defaults
    localparam int DEF_MAX_SLOTS       = 256;
    localparam int DEF_MAX_FRAME_WORDS = 64;
    localparam int DEF_WORD_BITS       = 64;

    // Configuration register reset values
    localparam logic [CNT_W-1:0] ENTRY_COUNT_RST   = CNT_W'(200);
    localparam logic [EW_W-1:0]  ELEMENT_WORDS_RST = EW_W'(40);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_COUNT   = 1'b0,
        REG_ELEMENT_WORDS = 1'b1
    } cfg_reg_t;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT       = 3'd0,
        CMD_GET       = 3'd1,
        CMD_SKIP      = 3'd2,
        CMD_BACKSPACE = 3'd3,
        CMD_COMPARE   = 3'd4,
        CMD_SET_FLAG  = 3'd5
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL    = 3'd0,
        ST_OVERWRITE = 3'd1,
        ST_SHORT     = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_MISMATCH  = 3'd4
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic exec_fire;
        logic stream_fire;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic start_stream;
        logic stream_last;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/ofrb_req_if.sv */
// Request channel of the frame ring buffer: command and frame word payload.
`timescale 1ns / 1ps
`default_nettype none

interface ofrb_req_if
    import ofrb_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
);
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [WORD_BITS-1:0] data_word;
    logic                 last_word;
    logic [CNT_W-1:0]     amount;
    logic                 flag_value;

    modport source (
        output valid, command, data_word, last_word, amount, flag_value,
        input  ready
    );

    modport sink (
        input  valid, command, data_word, last_word, amount, flag_value,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/ofrb_rsp_if.sv */
// Result channel of the frame ring buffer: read word and buffer status.
`timescale 1ns / 1ps
`default_nettype none

interface ofrb_rsp_if
    import ofrb_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] read_word;
    logic                 run_end;
    logic [STATUS_W-1:0]  status;
    logic [CNT_W-1:0]     fill_count;
    logic                 is_empty;
    logic                 is_full;
    logic                 transfer_flag;

    modport source (
        output valid, read_word, run_end, status, fill_count, is_empty, is_full,
               transfer_flag,
        input  ready
    );

    modport sink (
        input  valid, read_word, run_end, status, fill_count, is_empty, is_full,
               transfer_flag,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/ofrb_datapath.sv */
// Datapath of the frame ring buffer: frame memory, pointers, counters, result register.
`timescale 1ns / 1ps
`default_nettype none

module ofrb_datapath
    import ofrb_pkg::*;
#(
    parameter int MAX_SLOTS       = DEF_MAX_SLOTS,
    parameter int MAX_FRAME_WORDS = DEF_MAX_FRAME_WORDS,
    parameter int WORD_BITS       = DEF_WORD_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // request payload
    input  wire logic [CMD_W-1:0]     req_command,
    input  wire logic [WORD_BITS-1:0] req_data_word,
    input  wire logic                 req_last_word,
    input  wire logic [CNT_W-1:0]     req_amount,
    input  wire logic                 req_flag_value,
    // result channel
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output logic [WORD_BITS-1:0]      rsp_read_word,
    output logic                      rsp_run_end,
    output logic [STATUS_W-1:0]       rsp_status,
    output logic [CNT_W-1:0]          rsp_fill_count,
    output logic                      rsp_is_empty,
    output logic                      rsp_is_full,
    output logic                      rsp_transfer_flag,
    // controller link
    input  wire ctrl_cmd_t            ctrl,
    output dp_status_t                dp_stat
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int POS_W  = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1;
    localparam int ADDR_W = SLOT_W + POS_W;
    localparam int DEPTH  = MAX_SLOTS * (2 ** POS_W);
    localparam int SUM_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam int CMP_W  = ((POS_W > EW_W) ? POS_W : EW_W) + 1;

    // Frame memory
    logic [WORD_BITS-1:0] mem [DEPTH];

    // Configuration and control state
    logic [CNT_W-1:0]     ec_reg;
    logic [EW_W-1:0]      ew_reg;
    logic [SLOT_W-1:0]    head_reg,     head_next;
    logic [CNT_W-1:0]     held_reg,     held_next;
    logic [POS_W-1:0]     pos_reg,      pos_next;
    logic                 mis_reg,      mis_next;
    logic                 flag_reg,     flag_next;
    logic [SLOT_W-1:0]    get_slot_reg, get_slot_next;
    logic [POS_W-1:0]     k_reg,        k_next;
    logic                 out_valid_reg;

    // Latched transaction and payload registers
    logic [CMD_W-1:0]     cmd_reg;
    logic [WORD_BITS-1:0] data_reg;
    logic                 last_reg;
    logic [CNT_W-1:0]     amount_reg;
    logic                 flagv_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_BITS-1:0] out_word_reg;
    logic                 out_end_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [CNT_W-1:0]     out_fill_reg;
    logic                 out_empty_reg;
    logic                 out_full_reg;
    logic                 out_flag_reg;

    logic [CNT_W-1:0]     n_slots;
    logic [EW_W-1:0]      n_words;
    logic [SLOT_W-1:0]    tail_slot;
    logic [SLOT_W-1:0]    head_inc;
    logic [SLOT_W-1:0]    head_skip;
    logic [SLOT_W-1:0]    head_back;
    logic                 ends;
    logic                 short_frame;
    logic                 mis_cur;
    logic                 stream_last;
    logic                 res_load;
    status_t              res_status;
    logic                 start_stream;
    logic                 out_free;
    logic                 mem_we;
    logic [ADDR_W-1:0]    waddr;
    logic                 mem_re;
    logic [ADDR_W-1:0]    raddr;
    logic [POS_W-1:0]     rd_pos;

    // Add two slot offsets modulo the slot count; the sum stays below twice the count
    function automatic logic [SLOT_W-1:0] wrap_add(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b,
        input logic [SUM_W-1:0] m
    );
        logic [SUM_W-1:0] s;
        s = a + b;
        if (s >= m)
        begin
            s = s - m;
        end
        return SLOT_W'(s);
    endfunction

    // Clamp configuration to the supported ranges
    always_comb
    begin
        if (ec_reg == '0)
        begin
            n_slots = CNT_W'(1);
        end
        else if (32'(ec_reg) > MAX_SLOTS)
        begin
            n_slots = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            n_slots = ec_reg;
        end

        if (ew_reg == '0)
        begin
            n_words = EW_W'(1);
        end
        else if (32'(ew_reg) > MAX_FRAME_WORDS)
        begin
            n_words = EW_W'(MAX_FRAME_WORDS);
        end
        else
        begin
            n_words = ew_reg;
        end
    end

    // Slot pointer arithmetic
    assign tail_slot = wrap_add(SUM_W'(head_reg), SUM_W'(held_reg), SUM_W'(n_slots));
    assign head_inc  = wrap_add(SUM_W'(head_reg), SUM_W'(1), SUM_W'(n_slots));
    assign head_skip = wrap_add(SUM_W'(head_reg), SUM_W'(amount_reg), SUM_W'(n_slots));
    assign head_back = wrap_add(SUM_W'(head_reg), SUM_W'(held_reg - amount_reg),
                                SUM_W'(n_slots));

    // Frame end and match tracking for the latched transaction
    assign short_frame = (CMP_W'(pos_reg) + CMP_W'(1)) < CMP_W'(n_words);
    assign ends        = last_reg || !short_frame;
    assign mis_cur     = mis_reg || ((held_reg != '0) && (rdata_reg != data_reg));
    assign stream_last = (CMP_W'(k_reg) + CMP_W'(1)) == CMP_W'(n_words);
    assign out_free    = !out_valid_reg || rsp_ready;

    // Memory port control: put writes and the first read issue on acceptance
    assign mem_we = ctrl.accept && (req_command == CMD_PUT);
    assign waddr  = {tail_slot, pos_reg};
    assign rd_pos = (req_command == CMD_GET) ? '0 : pos_reg;
    assign mem_re = ctrl.accept || (ctrl.stream_fire && !stream_last);
    assign raddr  = ctrl.accept ? {head_reg, rd_pos} : {get_slot_reg, k_reg + POS_W'(1)};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= req_data_word;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Execute the latched command
    always_comb
    begin
        head_next     = head_reg;
        held_next     = held_reg;
        pos_next      = pos_reg;
        mis_next      = mis_reg;
        flag_next     = flag_reg;
        get_slot_next = get_slot_reg;
        k_next        = k_reg;
        res_load      = 1'b0;
        res_status    = ST_NORMAL;
        start_stream  = 1'b0;

        case (cmd_t'(cmd_reg))
            CMD_PUT:
            begin
                if (!ends)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    pos_next = '0;
                    mis_next = 1'b0;
                    res_load = 1'b1;
                    if (held_reg >= n_slots)
                    begin
                        head_next  = head_inc;
                        res_status = ST_OVERWRITE;
                    end
                    else
                    begin
                        held_next = held_reg + CNT_W'(1);
                    end
                end
            end
            CMD_COMPARE:
            begin
                if (!ends)
                begin
                    pos_next = pos_reg + POS_W'(1);
                    mis_next = mis_cur;
                end
                else
                begin
                    pos_next = '0;
                    mis_next = 1'b0;
                    res_load = 1'b1;
                    if (held_reg == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else if (mis_cur || short_frame)
                    begin
                        res_status = ST_MISMATCH;
                    end
                    else
                    begin
                        head_next = head_inc;
                        held_next = held_reg - CNT_W'(1);
                    end
                end
            end
            CMD_GET:
            begin
                pos_next = '0;
                mis_next = 1'b0;
                if (held_reg == '0)
                begin
                    res_load   = 1'b1;
                    res_status = ST_EMPTY;
                end
                else
                begin
                    start_stream  = 1'b1;
                    get_slot_next = head_reg;
                    head_next     = head_inc;
                    held_next     = held_reg - CNT_W'(1);
                    k_next        = '0;
                end
            end
            CMD_SKIP,
            CMD_BACKSPACE:
            begin
                pos_next = '0;
                mis_next = 1'b0;
                res_load = 1'b1;
                if (amount_reg > held_reg)
                begin
                    res_status = ST_SHORT;
                end
                else if (cmd_reg == CMD_SKIP)
                begin
                    head_next = head_skip;
                    held_next = held_reg - amount_reg;
                end
                else
                begin
                    head_next = head_back;
                    held_next = amount_reg;
                end
            end
            CMD_SET_FLAG:
            begin
                pos_next  = '0;
                mis_next  = 1'b0;
                flag_next = flagv_reg;
                res_load  = 1'b1;
            end
            default:
            begin
                pos_next = '0;
                mis_next = 1'b0;
                res_load = 1'b1;
            end
        endcase

        // advance the stream word counter
        if (ctrl.stream_fire)
        begin
            k_next = k_reg + POS_W'(1);
        end
    end

    // Control state: configuration writes re-initialize the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_reg        <= ENTRY_COUNT_RST;
            ew_reg        <= ELEMENT_WORDS_RST;
            head_reg      <= '0;
            held_reg      <= '0;
            pos_reg       <= '0;
            mis_reg       <= 1'b0;
            flag_reg      <= 1'b0;
            get_slot_reg  <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_ENTRY_COUNT)
                begin
                    ec_reg <= cfg_wdata[CNT_W-1:0];
                end
                else
                begin
                    ew_reg <= cfg_wdata[EW_W-1:0];
                end
                head_reg <= '0;
                held_reg <= '0;
                pos_reg  <= '0;
                mis_reg  <= 1'b0;
                flag_reg <= 1'b0;
            end
            else if (ctrl.exec_fire)
            begin
                head_reg     <= head_next;
                held_reg     <= held_next;
                pos_reg      <= pos_next;
                mis_reg      <= mis_next;
                flag_reg     <= flag_next;
                get_slot_reg <= get_slot_next;
                k_reg        <= k_next;
            end
            else if (ctrl.stream_fire)
            begin
                k_reg <= k_next;
            end

            // hold the result until the receiver takes it
            if ((ctrl.exec_fire && res_load) || ctrl.stream_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the transaction and load the result register
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg    <= req_command;
            data_reg   <= req_data_word;
            last_reg   <= req_last_word;
            amount_reg <= req_amount;
            flagv_reg  <= req_flag_value;
        end

        if (ctrl.exec_fire && res_load)
        begin
            out_word_reg   <= '0;
            out_end_reg    <= 1'b1;
            out_status_reg <= res_status;
            out_fill_reg   <= held_next;
            out_empty_reg  <= (held_next == '0);
            out_full_reg   <= (held_next == n_slots);
            out_flag_reg   <= flag_next;
        end
        else if (ctrl.stream_fire)
        begin
            out_word_reg   <= rdata_reg;
            out_end_reg    <= stream_last;
            out_status_reg <= ST_NORMAL;
            out_fill_reg   <= held_reg;
            out_empty_reg  <= (held_reg == '0);
            out_full_reg   <= (held_reg == n_slots);
            out_flag_reg   <= flag_reg;
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_read_word     = out_word_reg;
    assign rsp_run_end       = out_end_reg;
    assign rsp_status        = out_status_reg;
    assign rsp_fill_count    = out_fill_reg;
    assign rsp_is_empty      = out_empty_reg;
    assign rsp_is_full       = out_full_reg;
    assign rsp_transfer_flag = out_flag_reg;

    assign dp_stat.out_free     = out_free;
    assign dp_stat.start_stream = start_stream;
    assign dp_stat.stream_last  = stream_last;

endmodule

`default_nettype wire

/* rtl/core/ofrb_controller.sv */
// Controller of the frame ring buffer: sequences accept, execute and get streaming.
`timescale 1ns / 1ps
`default_nettype none

module ofrb_controller
    import ofrb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire dp_status_t dp_stat,
    output ctrl_cmd_t       ctrl
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_STREAM = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        req_ready        = 1'b0;
        ctrl.accept      = 1'b0;
        ctrl.exec_fire   = 1'b0;
        ctrl.stream_fire = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                ctrl.accept = req_valid;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait for room in the result register
                if (dp_stat.out_free)
                begin
                    ctrl.exec_fire = 1'b1;
                    state_next     = dp_stat.start_stream ? S_STREAM : S_IDLE;
                end
            end
            S_STREAM:
            begin
                if (dp_stat.out_free)
                begin
                    ctrl.stream_fire = 1'b1;
                    if (dp_stat.stream_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/overwriting_frame_ring_buffer_top.sv */
// Top level of the overwriting frame ring buffer: controller plus datapath.
// Usage:
//   request carries one transaction per command: put and compare send one frame
//   word per transaction (last_word or the configured frame length ends the frame),
//   get, skip, backspace and set flag take a single transaction.
//   result returns one item per command (put and compare at the frame end); a get
//   returns one per frame word with run_end on the last, or one item when empty.
// Timing:
//   A transaction is accepted in the idle state, which issues the frame memory
//   access (put write or head word read); the execute state runs it once the output
//   register is free and loads it if the command yields a result. A get streams its
//   words at one per cycle, paced by the registered read port of the frame memory.
//   While the receiver stalls, the output register holds and the block waits.
// Reset:
//   Pointers, fill count and transfer flag clear; slot count resets to 200 and
//   frame length to 40 words. The frame memory is not cleared. Any write to the
//   configuration port also clears pointers, fill count and flag.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_frame_ring_buffer_top
    import ofrb_pkg::*;
#(
    parameter int MAX_SLOTS       = DEF_MAX_SLOTS,
    parameter int MAX_FRAME_WORDS = DEF_MAX_FRAME_WORDS,
    parameter int WORD_BITS       = DEF_WORD_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    ofrb_req_if.sink                  request,
    ofrb_rsp_if.source                result
);

    ctrl_cmd_t  ctrl;
    dp_status_t dp_stat;

    // Sequence transactions
    ofrb_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .dp_stat   (dp_stat),
        .ctrl      (ctrl)
    );

    // Store frames and build results
    ofrb_datapath #(
        .MAX_SLOTS       (MAX_SLOTS),
        .MAX_FRAME_WORDS (MAX_FRAME_WORDS),
        .WORD_BITS       (WORD_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .req_command       (request.command),
        .req_data_word     (request.data_word),
        .req_last_word     (request.last_word),
        .req_amount        (request.amount),
        .req_flag_value    (request.flag_value),
        .rsp_valid         (result.valid),
        .rsp_ready         (result.ready),
        .rsp_read_word     (result.read_word),
        .rsp_run_end       (result.run_end),
        .rsp_status        (result.status),
        .rsp_fill_count    (result.fill_count),
        .rsp_is_empty      (result.is_empty),
        .rsp_is_full       (result.is_full),
        .rsp_transfer_flag (result.transfer_flag),
        .ctrl              (ctrl),
        .dp_stat           (dp_stat)
    );

endmodule

`default_nettype wire
